// ===== hdl/pkwc_pkg.sv =====
// Shared types and constants for the power key wake controller.
// Used by every module of the block but pkwc_checker. No dependencies.
`default_nettype none

package pkwc_pkg;

  localparam int TickW  = 10;
  localparam int HoldW  = 16;
  localparam int IdleW  = 20;
  localparam int AddrW  = 5;
  localparam int RegIdxW = 3;

  // Register indexes, byte address = 4 * index
  localparam logic [RegIdxW-1:0] RegTick       = 3'd0;
  localparam logic [RegIdxW-1:0] RegShortMin   = 3'd1;
  localparam logic [RegIdxW-1:0] RegLongPress  = 3'd2;
  localparam logic [RegIdxW-1:0] RegResetPress = 3'd3;
  localparam logic [RegIdxW-1:0] RegInactivity = 3'd4;
  localparam logic [RegIdxW-1:0] RegTouchHold  = 3'd5;

  localparam logic [TickW-1:0] TickRst       = 10'd20;
  localparam logic [HoldW-1:0] ShortMinRst   = 16'd60;
  localparam logic [HoldW-1:0] LongPressRst  = 16'd2000;
  localparam logic [HoldW-1:0] ResetPressRst = 16'd5000;
  localparam logic [IdleW-1:0] InactivityRst = 20'd30000;
  localparam logic [HoldW-1:0] TouchHoldRst  = 16'd120;

  typedef struct packed {
    logic [TickW-1:0] tick_ms;
    logic [HoldW-1:0] short_min_ms;
    logic [HoldW-1:0] long_hold_ms;
    logic [HoldW-1:0] reset_press_ms;
    logic [IdleW-1:0] inactivity_ms;
    logic [HoldW-1:0] touch_hold_ms;
  } cfg_t;

  // Packed highest bit first: screen_on, the last member, is bit 0
  typedef struct packed {
    logic touch_consumed;
    logic reset_request;
    logic slept;
    logic woke;
    logic screen_on;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/power_key_wake_controller_core.sv =====
// Power key wake controller, top level.
// Depends on pkwc_pkg, pkwc_regs and pkwc_step.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) takes one word per tick of
//    tick_ms: s_tdata[0] key_pressed, s_tdata[1] touch_pressed.
//  - Master stream (m_tvalid/m_tready/m_tdata) gives one word per tick:
//    screen_on, woke, slept, reset_request, touch_consumed from bit 0 up.
//  - APB-style port holds the six timing registers at byte addresses
//    0x00..0x14; write only while the block is idle.
// Timing:
//  - An accepted word goes into the input register, the state update runs on
//    it combinationally and lands in the output register once that register
//    is free. One word per cycle sustained while m_tready stays high, set
//    by the combinational state update loop.
//  - When the receiver stalls, the output register holds its word and the
//    input register still takes one more word; s_tready then drops until
//    m_tready returns.
//  - Reset (rst, synchronous) empties both registers, restores register
//    defaults and starts powered on with the key blocked until released.
`default_nettype none

module power_key_wake_controller_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,  // key_pressed, touch_pressed, pad
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [7:0]                 m_tdata,  // screen_on, woke, slept,
                                                    // reset_request, touch_consumed, pad
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pkwc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  pkwc_pkg::cfg_t    cfg;
  pkwc_pkg::result_t res;
  pkwc_pkg::result_t out_word;
  logic              in_valid;
  logic [1:0]        in_word;
  logic              advance;

  pkwc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  pkwc_step u_step (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .key   (in_word[0]),
    .touch (in_word[1]),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

  assign m_tdata = {3'd0, out_word};

endmodule

`default_nettype wire

// ===== hdl/pkwc_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on pkwc_pkg for register indexes, widths and reset values.
`default_nettype none

module pkwc_regs (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [pkwc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready,
  output pkwc_pkg::cfg_t               cfg
);

  logic                          wr_en;
  logic [pkwc_pkg::RegIdxW-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[pkwc_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms        <= pkwc_pkg::TickRst;
      cfg.short_min_ms   <= pkwc_pkg::ShortMinRst;
      cfg.long_hold_ms   <= pkwc_pkg::LongPressRst;
      cfg.reset_press_ms <= pkwc_pkg::ResetPressRst;
      cfg.inactivity_ms  <= pkwc_pkg::InactivityRst;
      cfg.touch_hold_ms  <= pkwc_pkg::TouchHoldRst;
    end else if (wr_en) begin
      case (idx)
        pkwc_pkg::RegTick:       cfg.tick_ms        <= pwdata[pkwc_pkg::TickW-1:0];
        pkwc_pkg::RegShortMin:   cfg.short_min_ms   <= pwdata[pkwc_pkg::HoldW-1:0];
        pkwc_pkg::RegLongPress:  cfg.long_hold_ms   <= pwdata[pkwc_pkg::HoldW-1:0];
        pkwc_pkg::RegResetPress: cfg.reset_press_ms <= pwdata[pkwc_pkg::HoldW-1:0];
        pkwc_pkg::RegInactivity: cfg.inactivity_ms  <= pwdata[pkwc_pkg::IdleW-1:0];
        pkwc_pkg::RegTouchHold:  cfg.touch_hold_ms  <= pwdata[pkwc_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pkwc_pkg::RegTick:       prdata = {22'd0, cfg.tick_ms};
      pkwc_pkg::RegShortMin:   prdata = {16'd0, cfg.short_min_ms};
      pkwc_pkg::RegLongPress:  prdata = {16'd0, cfg.long_hold_ms};
      pkwc_pkg::RegResetPress: prdata = {16'd0, cfg.reset_press_ms};
      pkwc_pkg::RegInactivity: prdata = {12'd0, cfg.inactivity_ms};
      pkwc_pkg::RegTouchHold:  prdata = {16'd0, cfg.touch_hold_ms};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pkwc_step.sv =====
// Controller state and the per-tick update: touch rule, key rule, inactivity rule.
// Depends on pkwc_pkg for cfg_t, result_t and widths.
`default_nettype none

module pkwc_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            key,
  input  wire logic            touch,
  input  wire pkwc_pkg::cfg_t  cfg,
  output pkwc_pkg::result_t    res
);

  localparam int HoldW = pkwc_pkg::HoldW;
  localparam int IdleW = pkwc_pkg::IdleW;
  localparam int TickW = pkwc_pkg::TickW;

  // low power is always the complement of power_on
  logic             power_on, power_on_next;
  logic             block_key, block_key_next;
  logic             ignore_touch, ignore_touch_next;
  logic             key_prev, key_prev_next;
  logic             reset_pulsed, reset_pulsed_next;
  logic             touch_tracking, touch_tracking_next;
  logic [HoldW-1:0] key_held_ms, key_held_ms_next;
  logic [HoldW-1:0] touch_held_ms, touch_held_ms_next;
  logic [IdleW-1:0] idle_ms, idle_ms_next;

  logic [IdleW:0]   idle_sum;
  logic [HoldW:0]   touch_sum;
  logic [HoldW:0]   key_sum;
  logic [HoldW-1:0] touch_sat;
  logic [HoldW-1:0] key_sat;

  assign idle_sum  = {1'b0, idle_ms} + {{(IdleW+1-TickW){1'b0}}, cfg.tick_ms};
  assign touch_sum = {1'b0, touch_held_ms} + {{(HoldW+1-TickW){1'b0}}, cfg.tick_ms};
  assign key_sum   = {1'b0, key_held_ms} + {{(HoldW+1-TickW){1'b0}}, cfg.tick_ms};
  assign touch_sat = touch_sum[HoldW] ? {HoldW{1'b1}} : touch_sum[HoldW-1:0];
  assign key_sat   = key_sum[HoldW] ? {HoldW{1'b1}} : key_sum[HoldW-1:0];

  always_comb begin
    power_on_next       = power_on;
    block_key_next      = block_key;
    ignore_touch_next   = ignore_touch;
    key_prev_next       = key_prev;
    reset_pulsed_next   = reset_pulsed;
    touch_tracking_next = touch_tracking;
    key_held_ms_next    = key_held_ms;
    touch_held_ms_next  = touch_held_ms;
    idle_ms_next        = idle_sum[IdleW] ? {IdleW{1'b1}} : idle_sum[IdleW-1:0];
    res                 = '0;

    // touch rule
    if (touch) begin
      if (touch_tracking) begin
        touch_held_ms_next = touch_sat;
      end else if (!power_on) begin
        touch_tracking_next = 1'b1;
        touch_held_ms_next  = '0;
      end
      idle_ms_next = '0;
      if (!power_on) begin
        if (!ignore_touch && touch_held_ms_next >= cfg.touch_hold_ms) begin
          power_on_next     = 1'b1;
          block_key_next    = 1'b1;
          res.woke          = 1'b1;
          ignore_touch_next = 1'b1;
        end
        res.touch_consumed = 1'b1;
      end else if (ignore_touch) begin
        res.touch_consumed = 1'b1;
      end
    end else begin
      ignore_touch_next   = 1'b0;
      touch_tracking_next = 1'b0;
      touch_held_ms_next  = '0;
    end

    // key rule, sees the state left by the touch rule
    if (block_key_next) begin
      if (!key) begin
        block_key_next    = 1'b0;
        key_prev_next     = 1'b0;
        key_held_ms_next  = '0;
        reset_pulsed_next = 1'b0;
      end else begin
        key_prev_next = 1'b1;
      end
    end else if (key) begin
      if (!key_prev && !power_on_next) begin
        power_on_next  = 1'b1;
        idle_ms_next   = '0;
        block_key_next = 1'b1;
        res.woke       = 1'b1;
      end else begin
        if (key_prev) begin
          key_held_ms_next = key_sat;
        end else begin
          key_held_ms_next  = {{(HoldW-TickW){1'b0}}, cfg.tick_ms};
          reset_pulsed_next = 1'b0;
        end
        if (!reset_pulsed_next && key_held_ms_next >= cfg.reset_press_ms) begin
          reset_pulsed_next = 1'b1;
          res.reset_request = 1'b1;
        end
        key_prev_next = 1'b1;
      end
    end else begin
      if (key_prev && !reset_pulsed && key_held_ms >= cfg.short_min_ms &&
          key_held_ms < cfg.long_hold_ms && power_on_next) begin
        power_on_next     = 1'b0;
        ignore_touch_next = 1'b0;
        res.slept         = 1'b1;
      end
      key_held_ms_next  = '0;
      reset_pulsed_next = 1'b0;
      key_prev_next     = 1'b0;
    end

    // inactivity rule
    if (power_on_next && idle_ms_next >= cfg.inactivity_ms) begin
      power_on_next     = 1'b0;
      ignore_touch_next = 1'b0;
      res.slept         = 1'b1;
    end

    res.screen_on = power_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on       <= 1'b1;
      block_key      <= 1'b1;
      ignore_touch   <= 1'b0;
      key_prev       <= 1'b0;
      reset_pulsed   <= 1'b0;
      touch_tracking <= 1'b0;
      key_held_ms    <= '0;
      touch_held_ms  <= '0;
      idle_ms        <= '0;
    end else if (en) begin
      power_on       <= power_on_next;
      block_key      <= block_key_next;
      ignore_touch   <= ignore_touch_next;
      key_prev       <= key_prev_next;
      reset_pulsed   <= reset_pulsed_next;
      touch_tracking <= touch_tracking_next;
      key_held_ms    <= key_held_ms_next;
      touch_held_ms  <= touch_held_ms_next;
      idle_ms        <= idle_ms_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pkwc_checker.sv =====
// Port-level checks for the power key wake controller, bound to the top level.
// Depends on power_key_wake_controller_core port names only.
`default_nettype none

module pkwc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       pready
);

  // a lone wake leaves the screen on
  a_wake_on: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] && !m_tdata[2] |-> m_tdata[0])
    else $error("woke without sleep but screen off");

  // any sleep in a word leaves the screen off
  a_sleep_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[0])
    else $error("slept but screen on");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind power_key_wake_controller_core pkwc_checker u_pkwc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for power_key_wake_controller_core: streams key/touch tick words, predicts
// each result word with a behavioral model of the wake logic and checks it field by field.
// Depends on pkwc_pkg and the RTL of the block.
`default_nettype none

module tb_top;

  localparam int unsigned IdleMax    = 32'hFFFFF;
  localparam int unsigned HoldMax    = 32'hFFFF;
  localparam int          QuietLimit = 1000;

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic [7:0]                   s_tdata  = '0;
  logic                         m_tready = 1'b0;
  logic                         psel     = 1'b0;
  logic                         penable  = 1'b0;
  logic                         pwrite   = 1'b0;
  logic [pkwc_pkg::AddrW-1:0]   paddr    = '0;
  logic [31:0]                  pwdata   = '0;
  logic                         s_tready;
  logic                         m_tvalid;
  logic [7:0]                   m_tdata;
  logic [31:0]                  prdata;
  logic                         pready;

  power_key_wake_controller_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the controller
  pkwc_pkg::cfg_t cfg;
  bit          pw_on, low_pwr, key_blocked, touch_ignored, key_was_down;
  bit          reset_issued, touch_tracked, woke_flag, slept_flag;
  int unsigned key_hold, touch_hold, idle_time;

  pkwc_pkg::result_t tick_results_q[$];
  int      mismatch_count = 0;
  int      words_checked  = 0;
  int      ticks_sent     = 0;
  bit      tx_gaps        = 1'b1;
  bit      rx_gaps        = 1'b1;
  int      rx_holdoff     = 0;
  string   field_name[5]  = '{"screen_on", "woke", "slept", "reset_request", "touch_consumed"};

  function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned mx);
    int unsigned s;
    s = a + b;
    return (s > mx) ? mx : s;
  endfunction

  function automatic void reset_model();
    cfg = '{pkwc_pkg::TickRst, pkwc_pkg::ShortMinRst, pkwc_pkg::LongPressRst,
            pkwc_pkg::ResetPressRst, pkwc_pkg::InactivityRst, pkwc_pkg::TouchHoldRst};
    pw_on = 1'b1; low_pwr = 1'b0; key_blocked = 1'b1; touch_ignored = 1'b0;
    key_was_down = 1'b0; reset_issued = 1'b0; touch_tracked = 1'b0;
    key_hold = 0; touch_hold = 0; idle_time = 0;
  endfunction

  function automatic void power_up();
    pw_on = 1'b1; low_pwr = 1'b0; idle_time = 0; key_blocked = 1'b1; woke_flag = 1'b1;
  endfunction

  function automatic void power_down();
    pw_on = 1'b0; low_pwr = 1'b1; touch_ignored = 1'b0; slept_flag = 1'b1;
  endfunction

  function automatic void store_register(logic [pkwc_pkg::RegIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      pkwc_pkg::RegTick:       cfg.tick_ms        = data[pkwc_pkg::TickW-1:0];
      pkwc_pkg::RegShortMin:   cfg.short_min_ms   = data[pkwc_pkg::HoldW-1:0];
      pkwc_pkg::RegLongPress:  cfg.long_hold_ms   = data[pkwc_pkg::HoldW-1:0];
      pkwc_pkg::RegResetPress: cfg.reset_press_ms = data[pkwc_pkg::HoldW-1:0];
      pkwc_pkg::RegInactivity: cfg.inactivity_ms  = data[pkwc_pkg::IdleW-1:0];
      pkwc_pkg::RegTouchHold:  cfg.touch_hold_ms  = data[pkwc_pkg::HoldW-1:0];
      default: ;
    endcase
  endfunction

  // One tick: touch rule, then key rule, then inactivity rule
  function automatic pkwc_pkg::result_t predict_tick(bit key, bit touch);
    pkwc_pkg::result_t r;
    int unsigned       step_ms;
    r = '0;
    step_ms = cfg.tick_ms;
    woke_flag = 1'b0;
    slept_flag = 1'b0;
    idle_time = sat_add(idle_time, step_ms, IdleMax);

    if (touch) begin
      if (touch_tracked) begin
        touch_hold = sat_add(touch_hold, step_ms, HoldMax);
      end else if (low_pwr) begin
        touch_tracked = 1'b1;
        touch_hold = 0;
      end
      idle_time = 0;
      if (low_pwr) begin
        if (!touch_ignored && touch_hold >= cfg.touch_hold_ms) begin
          power_up();
          touch_ignored = 1'b1;
        end
        r.touch_consumed = 1'b1;
      end else if (touch_ignored) begin
        r.touch_consumed = 1'b1;
      end
    end else begin
      touch_ignored = 1'b0;
      touch_tracked = 1'b0;
      touch_hold = 0;
    end

    if (key_blocked) begin
      if (!key) begin
        key_blocked = 1'b0;
        key_was_down = 1'b0;
        key_hold = 0;
        reset_issued = 1'b0;
      end else begin
        key_was_down = 1'b1;
      end
    end else if (key) begin
      if (!key_was_down && low_pwr) begin
        power_up();
      end else begin
        if (key_was_down) begin
          key_hold = sat_add(key_hold, step_ms, HoldMax);
        end else begin
          key_hold = step_ms;
          reset_issued = 1'b0;
        end
        if (!reset_issued && key_hold >= cfg.reset_press_ms) begin
          reset_issued = 1'b1;
          r.reset_request = 1'b1;
        end
        key_was_down = 1'b1;
      end
    end else begin
      if (key_was_down && !reset_issued && key_hold >= cfg.short_min_ms &&
          key_hold < cfg.long_hold_ms && pw_on)
        power_down();
      key_hold = 0;
      reset_issued = 1'b0;
      key_was_down = 1'b0;
    end

    if (!low_pwr && pw_on && idle_time >= cfg.inactivity_ms)
      power_down();

    r.screen_on = pw_on;
    r.woke = woke_flag;
    r.slept = slept_flag;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40)
      $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    pkwc_pkg::result_t got, want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = pkwc_pkg::result_t'(m_tdata[4:0]);
      if (tick_results_q.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = tick_results_q.pop_front();
        for (int i = 0; i < 5; i++)
          if (got[i] !== want[i])
            report_mismatch($sformatf("word %0d %s got %b want %b",
                                      words_checked, field_name[i], got[i], want[i]));
      end
      if (m_tdata[7:5] !== 3'b000)
        report_mismatch($sformatf("word %0d pad bits %b", words_checked, m_tdata[7:5]));
      words_checked++;
    end
  end

  // Receiver: random stall bursts, or one long hold-off when a test asks for it
  initial begin
    forever begin
      @(posedge clk);
      if (rx_holdoff > 0) begin
        m_tready <= 1'b0;
        repeat (rx_holdoff) @(posedge clk);
        rx_holdoff = 0;
        m_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
          (psel && penable && pwrite && pready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_tick(bit key, bit touch);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, touch, key};
    do @(posedge clk); while (s_tready !== 1'b1);
    tick_results_q.push_back(predict_tick(key, touch));
    ticks_sent++;
  endtask

  task automatic send_burst(int len, int key_pct, int touch_pct);
    repeat (len)
      send_tick($urandom_range(0, 99) < key_pct, $urandom_range(0, 99) < touch_pct);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  // Leaves psel high so back-to-back writes never toggle it within one step
  task automatic apb_write(logic [pkwc_pkg::RegIdxW-1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pkwc_pkg::AddrW'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    store_register(idx, data);
  endtask

  task automatic write_config(int unsigned tick, int unsigned short_min,
                              int unsigned long_press, int unsigned reset_press,
                              int unsigned inactivity, int unsigned touch_hold_val);
    wait_drained();
    apb_write(pkwc_pkg::RegTick, tick);
    apb_write(pkwc_pkg::RegShortMin, short_min);
    apb_write(pkwc_pkg::RegLongPress, long_press);
    apb_write(pkwc_pkg::RegResetPress, reset_press);
    apb_write(pkwc_pkg::RegInactivity, inactivity);
    apb_write(pkwc_pkg::RegTouchHold, touch_hold_val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Thresholds as small multiples of the tick so every rule is reachable
  task automatic random_config();
    int unsigned t;
    t = $urandom_range(1, 40);
    write_config(t, t * $urandom_range(0, 6), t * $urandom_range(2, 20),
                 t * $urandom_range(0, 35), t * $urandom_range(0, 60),
                 t * $urandom_range(0, 12));
  endtask

  // Well-formed presses and touches with random length, plus some noise
  task automatic run_episodes(int count);
    int target, kind, len;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 40);
      case (kind)
        0, 1, 2: send_burst(len, 100, 10);
        3, 4:    send_burst(len, 0, 100);
        5:       send_burst($urandom_range(1, 2), 100, 0);
        6:       send_burst(len, 0, 0);
        7:       send_burst(len, 50, 50);
        default: send_burst(len, 100, 100);
      endcase
      send_burst($urandom_range(1, 3), 0, 0);
    end
  endtask

  task automatic test_defaults_after_reset();
    send_tick(1, 0);              // key held out of reset stays blocked
    send_tick(0, 0);
    send_burst(3, 100, 0);        // 60 ms press: short press
    send_tick(0, 0);
    send_burst(8, 0, 100);        // touch wakes at 120 ms, then swallowed
    send_tick(0, 0);
    send_burst(3, 100, 0);
    send_tick(0, 0);
    send_tick(1, 1);              // fresh press in low power wakes
    send_tick(0, 0);
  endtask

  task automatic test_reset_request();
    write_config(20, 20, 2000, 40, 30000, 120);
    send_burst(2, 100, 0);
    send_tick(0, 0);              // release after reset pulse must not sleep
  endtask

  task automatic test_wake_and_sleep_same_tick();
    write_config(20, 60, 2000, 5000, 0, 0);
    send_tick(0, 0);
    send_tick(0, 1);
  endtask

  task automatic test_frozen_time();
    write_config(0, 0, 1, 0, 1, 0);
    send_tick(1, 0);
    send_tick(0, 0);
    send_tick(1, 0);
    send_tick(0, 0);
    send_tick(1, 0);
    send_tick(0, 0);
  endtask

  task automatic test_saturation();
    write_config(1023, 65535, 65535, 65535, 100000, 65535);
    send_burst(70, 100, 0);       // key hold saturates into the reset threshold
    send_tick(0, 0);
    send_burst(30, 0, 0);         // idle time runs out, inactivity sleep
    send_burst(70, 0, 100);       // touch hold saturates, wake
    send_tick(0, 0);
    write_config(0, 0, 0, 0, 0, 0);
    run_episodes(30);
  endtask

  task automatic test_backpressure();
    random_config();
    tx_gaps = 1'b0;
    rx_holdoff = 60;
    send_burst(30, 50, 50);
    wait_drained();
    send_burst(10, 50, 50);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_phases();
    repeat (3) begin
      random_config();
      run_episodes(50);
    end
    write_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_episodes(40);
  endtask

  task automatic test_no_idling();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_config();
    run_episodes(60);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_defaults_after_reset();
    test_reset_request();
    test_wake_and_sleep_same_tick();
    test_frozen_time();
    test_saturation();
    test_backpressure();
    test_random_phases();
    test_no_idling();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pkwc_pkg.sv
hdl/pkwc_regs.sv
hdl/pkwc_step.sv
hdl/power_key_wake_controller_core.sv
hdl/pkwc_checker.sv
sim/tb_top.sv
